/* rtl/core/sve_pkg.sv */
package sve_pkg;

   localparam int PHASE_BITS      = 24;
   localparam int TABLE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS     = 16;

   localparam int FRAC_BITS     = SAMPLE_BITS - 1;
   localparam int QUARTER       = 1 << (TABLE_ADDR_BITS - 2);
   localparam int ROM_IDX_BITS  = TABLE_ADDR_BITS - 1;
   localparam int REQ_DATA_BITS = ((PHASE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

   localparam int COEF_BITS = 16;
   localparam int ENV_BITS  = 17;
   localparam int ENV_ONE   = 65536;

   // one 18x18 (or sample-wide) signed multiplier is shared by the gain, envelope and final multiply steps
   localparam int MUL_A_BITS = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
   localparam int MUL_B_BITS = 18;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

   localparam logic [1:0] ACT_TICK     = 2'd0;
   localparam logic [1:0] ACT_NOTE_ON  = 2'd1;
   localparam logic [1:0] ACT_NOTE_OFF = 2'd2;

   localparam logic [1:0] CSR_RISE_COEF   = 2'd0;
   localparam logic [1:0] CSR_FALL_COEF   = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_GAIN = 2'd2;

   localparam logic [COEF_BITS-1:0] RISE_COEF_RESET   = 16'd683;
   localparam logic [COEF_BITS-1:0] FALL_COEF_RESET   = 16'd109;
   localparam logic [COEF_BITS-1:0] OUTPUT_GAIN_RESET = 16'd32768;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SAMPLE_MAX  = (64'd1 << FRAC_BITS) - 64'd1;

   typedef logic [QUARTER:0][FRAC_BITS-1:0] sat_rom_type;

   // restoring long division, only evaluated while the table is built
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sin(k/QUARTER * pi/2) in Q30, Taylor series in Horner form
   function automatic logic [63:0] quarter_sine_q30(input logic [63:0] k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      x  = (HALF_PI_Q30 * k) >> (TABLE_ADDR_BITS - 2);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
      return (x * t) >> 30;
   endfunction

   // round half up from Q30 to the sample format, clamp to full scale
   function automatic logic [63:0] q30_to_sample(input logic [63:0] v);
      logic [63:0] r;
      r = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (r > SAMPLE_MAX) begin
         r = SAMPLE_MAX;
      end
      return r;
   endfunction

   // magnitude of tanh(4*s) for a non-negative sample magnitude m
   function automatic logic [63:0] tanh_mag(input logic [63:0] m);
      logic [63:0] w;
      logic [63:0] e;
      logic [63:0] r;
      logic [63:0] t;
      w = m << (29 - FRAC_BITS);
      e = Q30_ONE;
      for (int n = 12; n >= 1; n--) begin
         e = Q30_ONE + div_u64((w * e) >> 30, 64'(n));
      end
      r = div_u64(64'd1 << 60, e);
      for (int i = 0; i < 4; i++) begin
         r = (r * r) >> 30;
      end
      if (r > Q30_ONE) begin
         r = Q30_ONE;
      end
      t = div_u64((Q30_ONE - r) << 30, Q30_ONE + r);
      return q30_to_sample(t);
   endfunction

   // quarter-wave table of the saturated sine, built at elaboration
   function automatic sat_rom_type build_sat_rom();
      sat_rom_type rom;
      logic [63:0] mag;
      for (int k = 0; k <= QUARTER; k++) begin
         mag    = tanh_mag(q30_to_sample(quarter_sine_q30(64'(k))));
         rom[k] = mag[FRAC_BITS-1:0];
      end
      return rom;
   endfunction

   localparam sat_rom_type SAT_ROM = build_sat_rom();

endpackage

/* rtl/core/sine_voice_saturated_envelope.sv */
// Tick item: once accepted it runs ST_READ, ST_GAIN, ST_ENV and ST_MUL, that is the
// quarter-wave table read plus three passes through one shared multiplier; rsp_tvalid
// and req_tready return together as it leaves ST_MUL, so nothing is accepted meanwhile,
// and a result not yet taken holds the last step until it is. Note-on, note-off and
// unused items complete in ST_IDLE. Synchronous active-high reset clears phase, step,
// envelope and gate and loads the register defaults; no clearing pass follows.
module sine_voice_saturated_envelope (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sve_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // phase_increment
   input  logic [1:0]                           req_tuser,  // action
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sve_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // sample
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [sve_pkg::COEF_BITS-1:0]        csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_GAIN = 5'b00100,
      ST_ENV  = 5'b01000,
      ST_MUL  = 5'b10000
   } state_type;

   localparam int PB = sve_pkg::PHASE_BITS;
   localparam int SB = sve_pkg::SAMPLE_BITS;
   localparam int AB = sve_pkg::TABLE_ADDR_BITS;
   localparam int YB = sve_pkg::MUL_P_BITS - 16;
   localparam logic signed [YB-1:0] Y_MAX = YB'((64'd1 << (SB - 1)) - 64'd1);
   localparam logic signed [YB-1:0] Y_MIN = -Y_MAX - YB'(1);

   state_type                           state_ff, state_in;
   logic [PB-1:0]                       phase_ff, phase_in;
   logic [PB-1:0]                       step_ff, step_in;
   logic [sve_pkg::ENV_BITS-1:0]        env_ff, env_in;
   logic                                gate_ff, gate_in;
   logic [sve_pkg::COEF_BITS-1:0]       rise_ff, fall_ff, gain_ff;
   logic signed [SB-1:0]                sat_ff, sat_in;
   logic signed [SB-1:0]                scaled_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]                       rsp_data_ff;

   logic                                req_fire;
   logic [AB-1:0]                       tbl_addr;
   logic [1:0]                          quad;
   logic [AB-3:0]                       tbl_j;
   logic [sve_pkg::ROM_IDX_BITS-1:0]    rom_idx;
   logic signed [SB-1:0]                rom_mag;

   logic signed [sve_pkg::MUL_A_BITS-1:0] mul_a;
   logic signed [sve_pkg::MUL_B_BITS-1:0] mul_b;
   logic signed [sve_pkg::MUL_P_BITS-1:0] mul_p;
   logic signed [YB-1:0]                  mul_q;
   logic signed [17:0]                    env_s, env_diff, env_sum;
   logic signed [SB-1:0]                  y_sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sve_pkg::RSP_DATA_BITS'(rsp_data_ff);

   // quarter-wave fold of the table address
   assign tbl_addr = phase_ff[PB-1 -: AB];
   assign quad     = tbl_addr[AB-1 -: 2];
   assign tbl_j    = tbl_addr[AB-3:0];
   assign rom_idx  = quad[0] ? sve_pkg::ROM_IDX_BITS'(sve_pkg::QUARTER) - {1'b0, tbl_j}
                             : {1'b0, tbl_j};
   assign rom_mag  = $signed({1'b0, sve_pkg::SAT_ROM[rom_idx]});
   assign sat_in   = quad[1] ? -rom_mag : rom_mag;

   // shared multiplier; >>> 16 is the top slice, which floors
   assign env_s    = $signed({1'b0, env_ff});
   assign env_diff = gate_ff ? 18'sd65536 - env_s : -env_s;

   always_comb begin
      case (state_ff)
         ST_GAIN: begin
            mul_a = sve_pkg::MUL_A_BITS'(sat_ff);
            mul_b = $signed({2'b00, gain_ff});
         end
         ST_ENV: begin
            mul_a = sve_pkg::MUL_A_BITS'(env_diff);
            mul_b = $signed({2'b00, gate_ff ? rise_ff : fall_ff});
         end
         ST_MUL: begin
            mul_a = sve_pkg::MUL_A_BITS'(scaled_ff);
            mul_b = $signed({1'b0, env_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign mul_q   = mul_p[sve_pkg::MUL_P_BITS-1:16];
   assign env_sum = env_s + mul_q[17:0];

   always_comb begin
      if (mul_q > Y_MAX) begin
         y_sat = SB'(Y_MAX);
      end else if (mul_q < Y_MIN) begin
         y_sat = SB'(Y_MIN);
      end else begin
         y_sat = mul_q[SB-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      gate_in      = gate_ff;
      env_in       = env_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  sve_pkg::ACT_TICK: begin
                     phase_in = phase_ff + step_ff;
                     state_in = ST_READ;
                  end
                  sve_pkg::ACT_NOTE_ON: begin
                     step_in = req_tdata[PB-1:0];
                     gate_in = 1'b1;
                  end
                  sve_pkg::ACT_NOTE_OFF: begin
                     gate_in = 1'b0;
                  end
                  default: begin
                     // drop the unused code
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            state_in = ST_ENV;
         end
         ST_ENV: begin
            if (env_sum > 18'sd65536) begin
               env_in = sve_pkg::ENV_BITS'(sve_pkg::ENV_ONE);
            end else begin
               env_in = env_sum[sve_pkg::ENV_BITS-1:0];
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         step_ff      <= '0;
         env_ff       <= '0;
         gate_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rise_ff      <= sve_pkg::RISE_COEF_RESET;
         fall_ff      <= sve_pkg::FALL_COEF_RESET;
         gain_ff      <= sve_pkg::OUTPUT_GAIN_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         env_ff       <= env_in;
         gate_ff      <= gate_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sve_pkg::CSR_RISE_COEF:   rise_ff <= csr_data;
               sve_pkg::CSR_FALL_COEF:   fall_ff <= csr_data;
               sve_pkg::CSR_OUTPUT_GAIN: gain_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         sat_ff <= sat_in;
      end
      if (state_ff == ST_GAIN) begin
         scaled_ff <= mul_q[SB-1:0];
      end
      if (state_ff == ST_MUL && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= y_sat;
      end
   end

   a_rsp_from_mul : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MUL))
      else $error("result raised outside the final multiply step");

   a_env_bound : assert property (@(posedge clock) disable iff (reset)
      env_ff <= sve_pkg::ENV_BITS'(sve_pkg::ENV_ONE))
      else $error("envelope above unity");

   a_release_falls : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ENV && !gate_ff) |=> env_ff <= $past(env_ff))
      else $error("envelope rose while the gate was clear");

   a_mul_holds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && rsp_valid_ff && !rsp_tready) |=> state_ff == ST_MUL)
      else $error("result step left while the output register was full");

endmodule
